@@ rtl/bpmd_pkg.sv @@
package bpmd_pkg;

  localparam int JOY_BITS_DEF = 10;

  localparam int PITCH_W    = 17;
  localparam int RATE_W     = 20;
  localparam int TRIM_W     = 13;
  localparam int GAIN_W     = 16;
  localparam int TILT_LIM_W = 15;
  localparam int MSA_W      = 12;
  localparam int DRV_W      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MSA       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 3'd6;

  localparam logic signed [TRIM_W-1:0] TRIM_RST    = -13'sd192;
  localparam logic [GAIN_W-1:0]        P_GAIN_RST  = 16'd3328;
  localparam logic [GAIN_W-1:0]        I_GAIN_RST  = 16'd15360;
  localparam logic [GAIN_W-1:0]        D_GAIN_RST  = 16'd51;
  localparam logic [TILT_LIM_W-1:0]    TILT_LIM_RST = 15'd3840;
  localparam logic [MSA_W-1:0]         MSA_RST     = 12'd768;
  localparam logic [DRV_W-1:0]         MAX_DRV_RST = 8'd255;

  // shared multiplier
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // datapath widths
  localparam int TILT_W   = 18;
  localparam int ERR_W    = 19;
  localparam int SP_Q_W   = 14;
  localparam int N_W      = 27;
  localparam int QD_W     = 21;
  localparam int ISUM_W   = 23;
  localparam int INT_W    = 18;
  localparam int ACC_W    = 38;
  localparam int DRIVE_SHIFT = 16;
  localparam int TRUNC_W  = ACC_W - DRIVE_SHIFT;
  localparam int DRIVE_W  = 9;

  // integral step: divide by 25600 = 256 * 100, the /100 by reciprocal
  localparam int I_PRE_SHIFT = 8;
  localparam int RECIP_SHIFT = 27;
  localparam logic [QD_W-1:0] RECIP = 21'd1342177;
  localparam logic [N_W-1:0]  I_DIV = 27'd100;
  localparam logic [ACC_W-1:0] TRUNC_ROUND = ACC_W'((1 << DRIVE_SHIFT) - 1);

  localparam int OUT_W       = 19;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic signed [TRIM_W-1:0] trim_angle;
    logic [GAIN_W-1:0]        p_gain;
    logic [GAIN_W-1:0]        i_gain;
    logic [GAIN_W-1:0]        d_gain;
    logic [TILT_LIM_W-1:0]    tilt_limit;
    logic [MSA_W-1:0]         max_setpoint_angle;
    logic [DRV_W-1:0]         max_drive;
  } cfg_t;

  // microcode
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_JOY    = 4'd0;
  localparam logic [OP_W-1:0] OP_FOLD1  = 4'd1;
  localparam logic [OP_W-1:0] OP_FOLD2  = 4'd2;
  localparam logic [OP_W-1:0] OP_SETP   = 4'd3;
  localparam logic [OP_W-1:0] OP_ERR    = 4'd4;
  localparam logic [OP_W-1:0] OP_MULI   = 4'd5;
  localparam logic [OP_W-1:0] OP_MULP   = 4'd6;
  localparam logic [OP_W-1:0] OP_RECIP  = 4'd7;
  localparam logic [OP_W-1:0] OP_QEST   = 4'd8;
  localparam logic [OP_W-1:0] OP_QFIX   = 4'd9;
  localparam logic [OP_W-1:0] OP_IADD   = 4'd10;
  localparam logic [OP_W-1:0] OP_ICLAMP = 4'd11;
  localparam logic [OP_W-1:0] OP_ACC    = 4'd12;
  localparam logic [OP_W-1:0] OP_DRIVE  = 4'd13;
  localparam logic [OP_W-1:0] OP_OUT    = 4'd14;

  localparam int BR_W = 1;
  localparam logic [BR_W-1:0] BR_NEXT      = 1'b0;
  localparam logic [BR_W-1:0] BR_WAIT_DONE = 1'b1;

  localparam int PC_W = 4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [BR_W-1:0] br;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic            fire;
    logic [OP_W-1:0] op;
  } ctrl_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_JOY,    BR_NEXT, 4'd0};
      4'd1:    w = '{OP_FOLD1,  BR_NEXT, 4'd0};
      4'd2:    w = '{OP_FOLD2,  BR_NEXT, 4'd0};
      4'd3:    w = '{OP_SETP,   BR_NEXT, 4'd0};
      4'd4:    w = '{OP_ERR,    BR_NEXT, 4'd0};
      4'd5:    w = '{OP_MULI,   BR_NEXT, 4'd0};
      4'd6:    w = '{OP_MULP,   BR_NEXT, 4'd0};
      4'd7:    w = '{OP_RECIP,  BR_NEXT, 4'd0};
      4'd8:    w = '{OP_QEST,   BR_NEXT, 4'd0};
      4'd9:    w = '{OP_QFIX,   BR_NEXT, 4'd0};
      4'd10:   w = '{OP_IADD,   BR_NEXT, 4'd0};
      4'd11:   w = '{OP_ICLAMP, BR_NEXT, 4'd0};
      4'd12:   w = '{OP_ACC,    BR_NEXT, 4'd0};
      4'd13:   w = '{OP_DRIVE,  BR_NEXT, 4'd0};
      4'd14:   w = '{OP_OUT,    BR_WAIT_DONE, 4'd14};
      default: w = '{OP_OUT,    BR_WAIT_DONE, 4'd14};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/balance_pid_motor_drive_unit.sv @@
// Channel  Direction  Handshake               Content
// s_*      in         s_tvalid / s_tready     one sample: pitch, pitch rate, joystick
// m_*      out        m_tvalid / m_tready     drive directions, duties, tilt cutoff
// cfg_*    in         cfg_valid / cfg_ready   register index and write data
//
// Each sample runs a 15-step microprogram on one shared 28x22 multiplier after
// the accept cycle; s_tready is low until it ends, so samples do not overlap.
// The last step waits while the previous result is still held on m_*.
// Reset (rst, synchronous) loads register defaults and clears the integral.
// cfg_ready is always high; unknown register indexes are dropped.
module balance_pid_motor_drive_unit #(
  parameter int JOYSTICK_BITS = bpmd_pkg::JOY_BITS_DEF,
  parameter int IN_W          = bpmd_pkg::PITCH_W + bpmd_pkg::RATE_W + JOYSTICK_BITS,
  parameter int IN_TDATA_W    = ((IN_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pitch_angle, angular_rate, joystick_y
  input  logic [IN_TDATA_W-1:0]               s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // left_forward, left_duty, right_forward, right_duty, tilt_cutoff
  output logic [bpmd_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RATE_LO = bpmd_pkg::PITCH_W;
  localparam int JOY_LO  = bpmd_pkg::PITCH_W + bpmd_pkg::RATE_W;

  bpmd_pkg::cfg_t  cfg;
  bpmd_pkg::ctrl_t ctrl;
  logic            busy;
  logic            start;
  logic            out_busy;

  assign s_tready  = !busy;
  assign start     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trim_angle         <= bpmd_pkg::TRIM_RST;
      cfg.p_gain             <= bpmd_pkg::P_GAIN_RST;
      cfg.i_gain             <= bpmd_pkg::I_GAIN_RST;
      cfg.d_gain             <= bpmd_pkg::D_GAIN_RST;
      cfg.tilt_limit         <= bpmd_pkg::TILT_LIM_RST;
      cfg.max_setpoint_angle <= bpmd_pkg::MSA_RST;
      cfg.max_drive          <= bpmd_pkg::MAX_DRV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpmd_pkg::REG_TRIM:      cfg.trim_angle <= cfg_data[bpmd_pkg::TRIM_W-1:0];
        bpmd_pkg::REG_P_GAIN:    cfg.p_gain     <= cfg_data[bpmd_pkg::GAIN_W-1:0];
        bpmd_pkg::REG_I_GAIN:    cfg.i_gain     <= cfg_data[bpmd_pkg::GAIN_W-1:0];
        bpmd_pkg::REG_D_GAIN:    cfg.d_gain     <= cfg_data[bpmd_pkg::GAIN_W-1:0];
        bpmd_pkg::REG_TILT_LIM:  cfg.tilt_limit <= cfg_data[bpmd_pkg::TILT_LIM_W-1:0];
        bpmd_pkg::REG_MSA:
          cfg.max_setpoint_angle <= cfg_data[bpmd_pkg::MSA_W-1:0];
        bpmd_pkg::REG_MAX_DRIVE: cfg.max_drive  <= cfg_data[bpmd_pkg::DRV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpmd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_busy (out_busy),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  bpmd_dp #(
    .JB (JOYSTICK_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .pitch_in (s_tdata[bpmd_pkg::PITCH_W-1:0]),
    .rate_in  (s_tdata[JOY_LO-1:RATE_LO]),
    .joy_in   (s_tdata[IN_W-1:JOY_LO]),
    .cfg      (cfg),
    .ctrl     (ctrl),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .out_busy (out_busy)
  );

endmodule

@@ rtl/bpmd_mul.sv @@
module bpmd_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [bpmd_pkg::MUL_A_W-1:0]   a,
  input  logic signed [bpmd_pkg::MUL_B_W-1:0]   b,
  output logic signed [bpmd_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

@@ rtl/bpmd_seq.sv @@
module bpmd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                out_busy,
  output bpmd_pkg::ctrl_t     ctrl,
  output logic                busy
);

  logic [bpmd_pkg::PC_W-1:0] pc;
  logic [bpmd_pkg::PC_W-1:0] pc_next;
  logic                      busy_next;
  bpmd_pkg::uword_t          uw;
  logic                      stall;

  assign uw    = bpmd_pkg::ucode(pc);
  assign stall = (uw.br == bpmd_pkg::BR_WAIT_DONE) && out_busy;

  assign ctrl.fire = busy && !stall;
  assign ctrl.op   = uw.op;

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (busy) begin
      unique case (uw.br)
        bpmd_pkg::BR_NEXT: begin
          pc_next = pc + bpmd_pkg::PC_W'(1);
        end
        bpmd_pkg::BR_WAIT_DONE: begin
          if (out_busy) begin
            pc_next = uw.target;
          end else begin
            pc_next   = '0;
            busy_next = 1'b0;
          end
        end
        default: pc_next = pc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

@@ rtl/bpmd_dp.sv @@
module bpmd_dp #(
  parameter int JB = bpmd_pkg::JOY_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [bpmd_pkg::PITCH_W-1:0]     pitch_in,
  input  logic signed [bpmd_pkg::RATE_W-1:0]      rate_in,
  input  logic [JB-1:0]                           joy_in,
  input  bpmd_pkg::cfg_t                          cfg,
  input  bpmd_pkg::ctrl_t                         ctrl,
  input  logic                                    m_tready,
  output logic                                    m_tvalid,
  output logic [bpmd_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    out_busy
);

  localparam int X_W  = JB + bpmd_pkg::MSA_W + 1;
  localparam int RA_W = JB + bpmd_pkg::SP_Q_W;
  localparam logic [JB-1:0] JMAX = '1;

  logic signed [bpmd_pkg::PITCH_W-1:0] pitch;
  logic signed [bpmd_pkg::RATE_W-1:0]  rate;
  logic [JB-1:0]                       joy;

  logic signed [bpmd_pkg::TILT_W-1:0]  tilt;
  logic                                cut;
  logic [bpmd_pkg::SP_Q_W-1:0]         qa;
  logic [RA_W-1:0]                     ra;
  logic signed [bpmd_pkg::ERR_W-1:0]   err;
  logic [bpmd_pkg::N_W-1:0]            n;
  logic                                neg;
  logic [bpmd_pkg::QD_W-1:0]           qd;
  logic signed [bpmd_pkg::ISUM_W-1:0]  isum;
  logic signed [bpmd_pkg::INT_W-1:0]   integ;
  logic signed [bpmd_pkg::ACC_W-1:0]   acc;
  logic signed [bpmd_pkg::DRIVE_W-1:0] drive;

  logic                                mul_en;
  logic signed [bpmd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bpmd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bpmd_pkg::MUL_P_W-1:0] prod;

  logic [X_W-1:0]                      x;
  logic [bpmd_pkg::MSA_W:0]            q0;
  logic [bpmd_pkg::SP_Q_W-1:0]         qa_fin;
  logic [bpmd_pkg::TILT_W-1:0]         abs_tilt;
  logic [bpmd_pkg::MUL_P_W-1:0]        pabs;
  logic [bpmd_pkg::N_W-1:0]            rem;
  logic signed [bpmd_pkg::ISUM_W-1:0]  istep;
  logic signed [bpmd_pkg::ISUM_W-1:0]  ilim;
  logic signed [bpmd_pkg::ACC_W-1:0]   iacc;
  logic signed [bpmd_pkg::ACC_W-1:0]   adj;
  logic signed [bpmd_pkg::TRUNC_W-1:0] trunc;
  logic signed [bpmd_pkg::TRUNC_W-1:0] dlim;
  logic [bpmd_pkg::DRIVE_W-1:0]        dabs;
  logic [bpmd_pkg::DRV_W-1:0]          duty;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (ctrl.op)
      bpmd_pkg::OP_JOY: begin
        mul_en = ctrl.fire;
        mul_a  = bpmd_pkg::MUL_A_W'(joy);
        mul_b  = bpmd_pkg::MUL_B_W'(cfg.max_setpoint_angle);
      end
      bpmd_pkg::OP_FOLD1: begin
        mul_en = ctrl.fire;
        mul_a  = bpmd_pkg::MUL_A_W'(rate);
        mul_b  = bpmd_pkg::MUL_B_W'(cfg.d_gain);
      end
      bpmd_pkg::OP_MULI: begin
        mul_en = ctrl.fire;
        mul_a  = bpmd_pkg::MUL_A_W'(err);
        mul_b  = bpmd_pkg::MUL_B_W'(cfg.i_gain);
      end
      bpmd_pkg::OP_MULP: begin
        mul_en = ctrl.fire;
        mul_a  = bpmd_pkg::MUL_A_W'(err);
        mul_b  = bpmd_pkg::MUL_B_W'(cfg.p_gain);
      end
      bpmd_pkg::OP_RECIP: begin
        mul_en = ctrl.fire;
        mul_a  = bpmd_pkg::MUL_A_W'(n);
        mul_b  = bpmd_pkg::MUL_B_W'(bpmd_pkg::RECIP);
      end
      default: mul_en = 1'b0;
    endcase
  end

  bpmd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // joy * 2 * msa / (2^JB - 1) by folding the high part back in
  assign x      = {prod[X_W-2:0], 1'b0};
  assign q0     = x[X_W-1:JB];
  assign qa_fin = qa + bpmd_pkg::SP_Q_W'(ra >= RA_W'(JMAX));

  assign abs_tilt = tilt[bpmd_pkg::TILT_W-1] ? bpmd_pkg::TILT_W'(-tilt)
                                             : bpmd_pkg::TILT_W'(tilt);
  assign pabs = prod[bpmd_pkg::MUL_P_W-1] ? bpmd_pkg::MUL_P_W'(-prod)
                                         : bpmd_pkg::MUL_P_W'(prod);
  assign rem  = n - bpmd_pkg::N_W'(qd) * bpmd_pkg::I_DIV;

  assign istep = neg ? -$signed(bpmd_pkg::ISUM_W'(qd)) : $signed(bpmd_pkg::ISUM_W'(qd));
  assign ilim  = $signed(bpmd_pkg::ISUM_W'({cfg.max_drive, 8'b0}));
  assign iacc  = bpmd_pkg::ACC_W'(integ);

  assign adj   = acc[bpmd_pkg::ACC_W-1] ? acc + $signed(bpmd_pkg::TRUNC_ROUND) : acc;
  assign trunc = adj[bpmd_pkg::ACC_W-1:bpmd_pkg::DRIVE_SHIFT];
  assign dlim  = $signed(bpmd_pkg::TRUNC_W'(cfg.max_drive));

  assign dabs = drive[bpmd_pkg::DRIVE_W-1] ? bpmd_pkg::DRIVE_W'(-drive)
                                          : bpmd_pkg::DRIVE_W'(drive);
  assign duty = cut ? '0 : dabs[bpmd_pkg::DRV_W-1:0];

  assign out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (start) begin
      pitch <= pitch_in;
      rate  <= rate_in;
      joy   <= joy_in;
    end
    if (rst) begin
      integ    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.fire && ctrl.op == bpmd_pkg::OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctrl.fire) begin
        case (ctrl.op)
          bpmd_pkg::OP_JOY: begin
            tilt <= bpmd_pkg::TILT_W'(pitch) - bpmd_pkg::TILT_W'(cfg.trim_angle);
          end
          bpmd_pkg::OP_FOLD1: begin
            qa <= bpmd_pkg::SP_Q_W'(q0);
            ra <= RA_W'(x[JB-1:0]) + RA_W'(q0);
          end
          bpmd_pkg::OP_FOLD2: begin
            qa  <= qa + bpmd_pkg::SP_Q_W'(ra >> JB);
            ra  <= RA_W'(ra[JB-1:0]) + (ra >> JB);
            acc <= bpmd_pkg::ACC_W'(prod);
            cut <= abs_tilt >= bpmd_pkg::TILT_W'(cfg.tilt_limit);
          end
          bpmd_pkg::OP_SETP: begin
            err <= bpmd_pkg::ERR_W'($signed({1'b0, qa_fin}))
                 - bpmd_pkg::ERR_W'($signed({1'b0, cfg.max_setpoint_angle}));
          end
          bpmd_pkg::OP_ERR: begin
            err <= err - bpmd_pkg::ERR_W'(tilt);
          end
          bpmd_pkg::OP_MULP: begin
            n   <= pabs[bpmd_pkg::N_W+bpmd_pkg::I_PRE_SHIFT-1:bpmd_pkg::I_PRE_SHIFT];
            neg <= prod[bpmd_pkg::MUL_P_W-1];
          end
          bpmd_pkg::OP_RECIP: begin
            acc <= acc + bpmd_pkg::ACC_W'(prod);
          end
          bpmd_pkg::OP_QEST: begin
            qd <= prod[bpmd_pkg::RECIP_SHIFT+bpmd_pkg::QD_W-1:bpmd_pkg::RECIP_SHIFT];
          end
          bpmd_pkg::OP_QFIX: begin
            qd <= qd + bpmd_pkg::QD_W'(rem >= bpmd_pkg::I_DIV);
          end
          bpmd_pkg::OP_IADD: begin
            isum <= bpmd_pkg::ISUM_W'(integ) + istep;
          end
          bpmd_pkg::OP_ICLAMP: begin
            if (isum > ilim) begin
              integ <= bpmd_pkg::INT_W'(ilim);
            end else if (isum < -ilim) begin
              integ <= bpmd_pkg::INT_W'(-ilim);
            end else begin
              integ <= bpmd_pkg::INT_W'(isum);
            end
          end
          bpmd_pkg::OP_ACC: begin
            acc <= acc + (iacc <<< 8);
          end
          bpmd_pkg::OP_DRIVE: begin
            if (trunc > dlim) begin
              drive <= bpmd_pkg::DRIVE_W'(dlim);
            end else if (trunc < -dlim) begin
              drive <= bpmd_pkg::DRIVE_W'(-dlim);
            end else begin
              drive <= bpmd_pkg::DRIVE_W'(trunc);
            end
            if (cut) begin
              integ <= '0;
            end
          end
          bpmd_pkg::OP_OUT: begin
            m_tdata <= {(bpmd_pkg::OUT_TDATA_W - bpmd_pkg::OUT_W)'(0),
                        cut,
                        duty,
                        (drive > 0),
                        duty,
                        drive[bpmd_pkg::DRIVE_W-1]};
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ bench/balance_pid_motor_drive_unit_test.sv @@
`timescale 1ns / 1ps

module balance_pid_motor_drive_unit_test;
  import bpmd_pkg::*;

  localparam int SAMPLE_W = ((PITCH_W + RATE_W + JOY_BITS_DEF + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SEGMENTS = 12;
  localparam int SEG_ITEMS = 130;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic       tilt_cutoff;
    logic [7:0] right_duty;
    logic       right_forward;
    logic [7:0] left_duty;
    logic       left_forward;
  } drive_result_t;

  class drive_scoreboard;
    logic signed [TRIM_W-1:0] trim;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic [TILT_LIM_W-1:0]    tilt_lim;
    logic [MSA_W-1:0]         msa;
    logic [DRV_W-1:0]         md;
    longint                   integ;
    drive_result_t            expected_q[$];
    int                       errors;

    function new();
      trim = TRIM_RST;
      kp = P_GAIN_RST;
      ki = I_GAIN_RST;
      kd = D_GAIN_RST;
      tilt_lim = TILT_LIM_RST;
      msa = MSA_RST;
      md = MAX_DRV_RST;
      integ = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TRIM:      trim = d[TRIM_W-1:0];
        REG_P_GAIN:    kp = d;
        REG_I_GAIN:    ki = d;
        REG_D_GAIN:    kd = d;
        REG_TILT_LIM:  tilt_lim = d[TILT_LIM_W-1:0];
        REG_MSA:       msa = d[MSA_W-1:0];
        REG_MAX_DRIVE: md = d[DRV_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] w);
      longint pitch, rate, joy, setp, tilt, err, sum, drv, lim, mag, abs_tilt;
      logic cut;
      drive_result_t r;
      pitch = $signed(w[16:0]);
      rate = $signed(w[36:17]);
      joy = w[46:37];
      lim = md;
      setp = (joy * 2 * longint'(msa)) / 1023 - longint'(msa);
      tilt = pitch - longint'(trim);
      err = setp - tilt;
      integ = integ + (err * longint'(ki)) / 25600;
      if (integ > lim * 256) integ = lim * 256;
      if (integ < -lim * 256) integ = -lim * 256;
      sum = err * longint'(kp) + integ * 256 + rate * longint'(kd);
      drv = sum / 65536;
      if (drv > lim) drv = lim;
      if (drv < -lim) drv = -lim;
      abs_tilt = (tilt < 0) ? -tilt : tilt;
      cut = (abs_tilt >= longint'(tilt_lim));
      if (cut) integ = 0;
      mag = (drv < 0) ? -drv : drv;
      r.left_forward = (-drv > 0);
      r.right_forward = (drv > 0);
      r.left_duty = cut ? 8'd0 : mag[7:0];
      r.right_duty = cut ? 8'd0 : mag[7:0];
      r.tilt_cutoff = cut;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
      drive_result_t got, want;
      got = word[OUT_W-1:0];
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", int'(word), 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.left_forward != want.left_forward)
        report_mismatch("left_forward", got.left_forward, want.left_forward);
      if (got.left_duty != want.left_duty)
        report_mismatch("left_duty", got.left_duty, want.left_duty);
      if (got.right_forward != want.right_forward)
        report_mismatch("right_forward", got.right_forward, want.right_forward);
      if (got.right_duty != want.right_duty)
        report_mismatch("right_duty", got.right_duty, want.right_duty);
      if (got.tilt_cutoff != want.tilt_cutoff)
        report_mismatch("tilt_cutoff", got.tilt_cutoff, want.tilt_cutoff);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int cur_trim = -192;
  int cur_tilt = 3840;

  balance_pid_motor_drive_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // cfg_valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TRIM) cur_trim = int'($signed(d[TRIM_W-1:0]));
    if (idx == REG_TILT_LIM) cur_tilt = int'(d[TILT_LIM_W-1:0]);
  endtask

  task automatic send_sample(int pitch, int rate, int joy);
    logic [31:0] p, r, j;
    p = pitch;
    r = rate;
    j = joy;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, j[9:0], r[19:0], p[16:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apply_setting(int seg);
    case (seg)
      0: begin
        write_reg(REG_TRIM, 16'(TRIM_RST));
        write_reg(REG_P_GAIN, P_GAIN_RST);
        write_reg(REG_I_GAIN, I_GAIN_RST);
        write_reg(REG_D_GAIN, D_GAIN_RST);
        write_reg(REG_TILT_LIM, 16'(TILT_LIM_RST));
        write_reg(REG_MSA, 16'(MSA_RST));
        write_reg(REG_MAX_DRIVE, 16'(MAX_DRV_RST));
        write_reg(REG_UNUSED, 16'hFFFF);
      end
      1: begin
        write_reg(REG_TRIM, 16'd2560);
        write_reg(REG_P_GAIN, 16'hFFFF);
        write_reg(REG_I_GAIN, 16'hFFFF);
        write_reg(REG_D_GAIN, 16'hFFFF);
        write_reg(REG_TILT_LIM, 16'd23040);
        write_reg(REG_MSA, 16'd2560);
        write_reg(REG_MAX_DRIVE, 16'd255);
      end
      2: begin
        write_reg(REG_TRIM, 16'(-2560));
        write_reg(REG_P_GAIN, 16'd0);
        write_reg(REG_I_GAIN, 16'd0);
        write_reg(REG_D_GAIN, 16'd0);
        write_reg(REG_TILT_LIM, 16'd0);
        write_reg(REG_MSA, 16'd0);
        write_reg(REG_MAX_DRIVE, 16'd0);
      end
      4: begin
        // raw 16-bit writes, upper bits dropped by the block
        write_reg(REG_TRIM, 16'($urandom));
        write_reg(REG_P_GAIN, 16'($urandom));
        write_reg(REG_I_GAIN, 16'($urandom));
        write_reg(REG_D_GAIN, 16'($urandom));
        write_reg(REG_TILT_LIM, 16'($urandom));
        write_reg(REG_MSA, 16'($urandom));
        write_reg(REG_MAX_DRIVE, 16'($urandom));
        write_reg(REG_UNUSED, 16'($urandom));
      end
      default: begin
        write_reg(REG_TRIM, 16'(rand_between(-2560, 2560)));
        write_reg(REG_P_GAIN, 16'($urandom_range(8000)));
        write_reg(REG_I_GAIN, 16'($urandom));
        write_reg(REG_D_GAIN, 16'($urandom_range(300)));
        write_reg(REG_TILT_LIM, (seg == 6) ? 16'd0 : 16'($urandom_range(23040)));
        write_reg(REG_MSA, 16'($urandom_range(2560)));
        write_reg(REG_MAX_DRIVE, (seg == 5) ? 16'd0 : 16'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic send_random();
    int pitch, rate, joy, roll;
    roll = $urandom_range(99);
    if (roll < 80) pitch = cur_trim + rand_between(-(cur_tilt + 64), cur_tilt + 64);
    else pitch = $urandom;
    roll = $urandom_range(99);
    if (roll < 60) rate = rand_between(-512000, 512000);
    else if (roll < 90) rate = rand_between(-2000, 2000);
    else rate = $urandom;
    roll = $urandom_range(99);
    if (roll < 5) joy = 0;
    else if (roll < 10) joy = 1023;
    else joy = $urandom_range(1023);
    send_sample(pitch, rate, joy);
  endtask

  initial begin
    int seg;
    send_idle_pct = 38;
    recv_idle_pct = 87;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(cur_trim, 0, 512);
    send_sample(-46080, 0, 0);
    send_sample(46080, 0, 1023);
    send_sample(-65536, -524288, 0);
    send_sample(65535, 524287, 1023);
    send_sample(cur_trim, 512000, 512);
    send_sample(cur_trim, -512000, 512);
    // tilt exactly at and just inside the cutoff
    send_sample(cur_trim + 3840, 0, 512);
    send_sample(cur_trim + 3839, 0, 512);
    send_sample(cur_trim - 3840, 0, 512);
    send_sample(cur_trim - 3839, 0, 512);
    // wind the integral up, then clear it with a cutoff
    repeat (6) send_sample(cur_trim - 1000, 0, 1023);
    send_sample(cur_trim + 3840, 0, 0);
    send_sample(cur_trim, 0, 1023);
    send_sample(cur_trim, 0, 0);
    send_sample(0, 1, 1);
    send_sample(-1, -1, 1022);
    wait_drain();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 87;
        recv_idle_pct = 38;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(seg);
      cfg_valid <= 1'b0;
      @(posedge clk);
      repeat (SEG_ITEMS) send_random();
      wait_drain();
    end

    if (sb.pending() != 0) sb.report_mismatch("results missing", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
